[sv/pdhb_pkg.sv]
package pdhb_pkg;

  // Fixed field widths
  localparam int WORD_BITS  = 32;
  localparam int OP_BITS    = 8;
  localparam int REG_BITS   = 4;
  localparam int IMM_BITS   = 12;
  localparam int FPC_BITS   = 10;
  localparam int LINK_BITS  = 11;
  localparam int STAGES     = 3;
  localparam int DESTS_BITS = STAGES * REG_BITS;

  // Default program counter width
  localparam int PC_BITS_DEF = 10;

  // Opcodes with special handling
  localparam logic [OP_BITS-1:0] OP_BEQ   = 8'd9;
  localparam logic [OP_BITS-1:0] OP_BNE   = 8'd10;
  localparam logic [OP_BITS-1:0] OP_BLT   = 8'd11;
  localparam logic [OP_BITS-1:0] OP_BGT   = 8'd12;
  localparam logic [OP_BITS-1:0] OP_BLE   = 8'd13;
  localparam logic [OP_BITS-1:0] OP_BGE   = 8'd14;
  localparam logic [OP_BITS-1:0] OP_JAL   = 8'd15;
  localparam logic [OP_BITS-1:0] OP_LOAD  = 8'd16;
  localparam logic [OP_BITS-1:0] OP_STORE = 8'd17;
  localparam logic [OP_BITS-1:0] OP_HALT  = 8'd20;

  // Register indices with fixed meaning
  localparam logic [REG_BITS-1:0] REG_ZERO = 4'd0;
  localparam logic [REG_BITS-1:0] REG_IMM  = 4'd1;

  typedef struct packed {
    logic                  slot_valid;
    logic [WORD_BITS-1:0]  instruction;
    logic [FPC_BITS-1:0]   fetch_pc;
    logic [WORD_BITS-1:0]  src_a_raw;
    logic [WORD_BITS-1:0]  src_b_raw;
    logic [WORD_BITS-1:0]  dest_raw;
    logic [DESTS_BITS-1:0] later_dests;
    logic [STAGES-1:0]     later_writes;
  } dec_in_t;

  typedef struct packed {
    logic                 stall_res;
    logic                 redirect;
    logic [FPC_BITS-1:0]  target_pc;
    logic                 link_write;
    logic [LINK_BITS-1:0] link_value;
    logic                 halt;
    logic                 issue_valid;
    logic [OP_BITS-1:0]   opcode_out;
    logic [WORD_BITS-1:0] dest_or_store;
    logic [WORD_BITS-1:0] src_a_value;
    logic [WORD_BITS-1:0] src_b_value;
    logic                 writes_register;
  } dec_out_t;

endpackage

[sv/pdhb_in_if.sv]
interface pdhb_in_if import pdhb_pkg::*; ();
  logic    valid;
  logic    ready;
  dec_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/pdhb_out_if.sv]
interface pdhb_out_if import pdhb_pkg::*; ();
  logic     valid;
  logic     ready;
  dec_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/pdhb_decode.sv]
module pdhb_decode import pdhb_pkg::*; #(
  parameter int PC_BITS = PC_BITS_DEF
) (
  input  dec_in_t  item,
  output dec_out_t result
);

  // Target and link bits kept under the pc width
  localparam int KEEP = (PC_BITS < FPC_BITS) ? PC_BITS : FPC_BITS;

  logic [OP_BITS-1:0]   op;
  logic [REG_BITS-1:0]  rd;
  logic [REG_BITS-1:0]  rs;
  logic [REG_BITS-1:0]  rt;
  logic [WORD_BITS-1:0] imm_ext;
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] b;
  logic [WORD_BITS-1:0] d;
  logic [FPC_BITS-1:0]  pc_mask;
  logic                 checked;
  logic                 hazard;
  logic                 is_branch;
  logic                 taken;
  logic [REG_BITS-1:0]  dst;

  // Field split and operand resolution
  always_comb begin
    op      = item.instruction[31:24];
    rd      = item.instruction[23:20];
    rs      = item.instruction[19:16];
    rt      = item.instruction[15:12];
    imm_ext = {{(WORD_BITS-IMM_BITS){item.instruction[IMM_BITS-1]}},
               item.instruction[IMM_BITS-1:0]};
    a = (rs == REG_ZERO) ? '0 : (rs == REG_IMM) ? imm_ext : item.src_a_raw;
    b = (rt == REG_ZERO) ? '0 : (rt == REG_IMM) ? imm_ext : item.src_b_raw;
    d = (rd == REG_ZERO) ? '0 : (rd == REG_IMM) ? imm_ext : item.dest_raw;
    for (int i = 0; i < FPC_BITS; i++) begin
      pc_mask[i] = (i < KEEP);
    end
  end

  // Read-after-write check against the later stages
  always_comb begin
    checked = (op <= OP_BGE) || (op == OP_LOAD) || (op == OP_STORE);
    hazard  = 1'b0;
    dst     = '0;
    for (int s = 0; s < STAGES; s++) begin
      dst = item.later_dests[s*REG_BITS +: REG_BITS];
      if (item.later_writes[s]) begin
        if ((rs > REG_IMM && rs == dst) || (rt > REG_IMM && rt == dst) ||
            (op == OP_STORE && rd > REG_IMM && rd == dst)) begin
          hazard = 1'b1;
        end
      end
    end
    hazard = hazard && checked;
  end

  // Branch condition
  always_comb begin
    is_branch = (op >= OP_BEQ) && (op <= OP_BGE);
    case (op)
      OP_BEQ:  taken = (a == b);
      OP_BNE:  taken = (a != b);
      OP_BLT:  taken = ($signed(a) < $signed(b));
      OP_BGT:  taken = ($signed(b) < $signed(a));
      OP_BLE:  taken = !($signed(b) < $signed(a));
      OP_BGE:  taken = !($signed(a) < $signed(b));
      default: taken = 1'b0;
    endcase
  end

  // Result assembly: bubble and stall give an otherwise empty result
  always_comb begin
    result = '0;
    if (item.slot_valid) begin
      if (hazard) begin
        result.stall_res = 1'b1;
      end else begin
        if (is_branch && taken) begin
          result.redirect  = 1'b1;
          result.target_pc = d[FPC_BITS-1:0] & pc_mask;
        end else if (op == OP_JAL) begin
          result.redirect   = 1'b1;
          result.target_pc  = d[FPC_BITS-1:0] & pc_mask;
          result.link_write = 1'b1;
          result.link_value = {1'b0, item.fetch_pc & pc_mask} + LINK_BITS'(1);
        end else if (op == OP_HALT) begin
          result.halt = 1'b1;
        end
        result.issue_valid     = 1'b1;
        result.opcode_out      = op;
        result.dest_or_store   = (op == OP_STORE) ? d : {{(WORD_BITS-REG_BITS){1'b0}}, rd};
        result.src_a_value     = a;
        result.src_b_value     = b;
        result.writes_register = (op < OP_BEQ) || (op == OP_JAL) || (op == OP_LOAD);
      end
    end
  end

endmodule

[sv/pipeline_decode_hazard_branch_unit.sv]
// Channel   Dir  Carries
// -------   ---  -------------------------------------------------------
// instr_in  in   decode latch, register reads, later-stage dests/writes
// dec_out   out  stall, redirect/target, link, halt, issue and operands
//
// One item per clock while dec_out is ready: an input register and a
// result register with the decode logic between them.
// Synchronous active-high rst clears both valid flags; payload is not reset.
// A full result register that is not taken holds the input register, which
// still takes a new item when it is empty or moving on.
module pipeline_decode_hazard_branch_unit import pdhb_pkg::*; #(
  parameter int PC_BITS = PC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  pdhb_in_if.sink     instr_in,
  pdhb_out_if.source  dec_out
);

  logic     s1_valid;
  dec_in_t  s1_data;
  logic     out_valid;
  dec_out_t out_data;
  dec_out_t result;
  logic     out_free;
  logic     s1_free;

  // Ready chain
  assign out_free       = !out_valid || dec_out.ready;
  assign s1_free        = !s1_valid || out_free;
  assign instr_in.ready = s1_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= instr_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && instr_in.valid) begin
      s1_data <= instr_in.data;
    end
  end

  pdhb_decode #(
    .PC_BITS (PC_BITS)
  ) u_decode (
    .item   (s1_data),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data <= result;
    end
  end

  assign dec_out.valid = out_valid;
  assign dec_out.data  = out_data;

endmodule

[tb/pipeline_decode_hazard_branch_unit_tb.sv]
module pipeline_decode_hazard_branch_unit_tb;
  import pdhb_pkg::*;

  // Opcodes used by the stimulus that the package does not name
  localparam logic [OP_BITS-1:0] OP_ALU0       = 8'd0;
  localparam logic [OP_BITS-1:0] OP_ALU_MID    = 8'd4;
  localparam logic [OP_BITS-1:0] OP_ALU_LAST   = 8'd8;
  localparam logic [OP_BITS-1:0] OP_UNDEF_LO   = 8'd18;
  localparam logic [OP_BITS-1:0] OP_UNDEF_HI   = 8'd19;
  localparam logic [OP_BITS-1:0] OP_UNDEF_NEXT = 8'd21;
  localparam logic [OP_BITS-1:0] OP_MAX        = 8'd255;

  localparam int NUM_RANDOM  = 1825;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  // Expected decode results, predicted from each accepted instruction
  class decode_result_tracker;
    dec_out_t expected_decodes[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return expected_decodes.size();
    endfunction

    // Register read: r0 is zero, r1 is the sign-extended immediate
    function logic [WORD_BITS-1:0] read_reg(logic [REG_BITS-1:0] idx,
                                            logic [WORD_BITS-1:0] imm_ext,
                                            logic [WORD_BITS-1:0] raw);
      if (idx == REG_ZERO) return '0;
      if (idx == REG_IMM) return imm_ext;
      return raw;
    endfunction

    function bit reg_clash(logic [REG_BITS-1:0] idx, logic [REG_BITS-1:0] dst);
      return idx > REG_IMM && idx == dst;
    endfunction

    function dec_out_t decode_word(dec_in_t item);
      dec_out_t                res;
      logic [OP_BITS-1:0]      op;
      logic [REG_BITS-1:0]     rd, rs, rt, dst;
      logic [WORD_BITS-1:0]    imm_ext, a, b, d;
      bit                      hazard, taken;
      res = '0;
      if (!item.slot_valid) return res;
      op      = item.instruction[31:24];
      rd      = item.instruction[23:20];
      rs      = item.instruction[19:16];
      rt      = item.instruction[15:12];
      imm_ext = {{(WORD_BITS-IMM_BITS){item.instruction[IMM_BITS-1]}},
                 item.instruction[IMM_BITS-1:0]};
      a = read_reg(rs, imm_ext, item.src_a_raw);
      b = read_reg(rt, imm_ext, item.src_b_raw);
      d = read_reg(rd, imm_ext, item.dest_raw);

      // RAW hazard against the later stages; jal, halt, undefined skip it
      hazard = 1'b0;
      if (op <= OP_BGE || op == OP_LOAD || op == OP_STORE) begin
        for (int s = 0; s < STAGES; s++) begin
          dst = item.later_dests[s*REG_BITS +: REG_BITS];
          if (item.later_writes[s] && (reg_clash(rs, dst) || reg_clash(rt, dst) ||
              (op == OP_STORE && reg_clash(rd, dst))))
            hazard = 1'b1;
        end
      end
      if (hazard) begin
        res.stall_res = 1'b1;
        return res;
      end

      // Signed branch compares
      case (op)
        OP_BEQ:  taken = a == b;
        OP_BNE:  taken = a != b;
        OP_BLT:  taken = $signed(a) < $signed(b);
        OP_BGT:  taken = $signed(a) > $signed(b);
        OP_BLE:  taken = $signed(a) <= $signed(b);
        OP_BGE:  taken = $signed(a) >= $signed(b);
        default: taken = 1'b0;
      endcase
      if (taken || op == OP_JAL) begin
        res.redirect  = 1'b1;
        res.target_pc = d[FPC_BITS-1:0];
      end
      if (op == OP_JAL) begin
        res.link_write = 1'b1;
        res.link_value = {1'b0, item.fetch_pc} + LINK_BITS'(1);
      end
      res.halt            = op == OP_HALT;
      res.issue_valid     = 1'b1;
      res.opcode_out      = op;
      res.dest_or_store   = (op == OP_STORE) ? d : {{(WORD_BITS-REG_BITS){1'b0}}, rd};
      res.src_a_value     = a;
      res.src_b_value     = b;
      res.writes_register = op <= OP_LOAD && !(op >= OP_BEQ && op <= OP_BGE);
      return res;
    endfunction

    function void note_input(dec_in_t item);
      expected_decodes.push_back(decode_word(item));
    endfunction

    function bit field_ok(string name, logic [WORD_BITS-1:0] want,
                          logic [WORD_BITS-1:0] got);
      if (want === got) return 1'b1;
      if (mismatches < MAX_REPORTS)
        $display("%0t decode mismatch on %s: expected %h actual %h", $time, name, want, got);
      return 1'b0;
    endfunction

    function void check_result(dec_out_t got);
      dec_out_t want;
      bit       ok;
      if (expected_decodes.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t decode result %h arrived with nothing pending", $time, got);
        mismatches++;
        return;
      end
      want = expected_decodes.pop_front();
      ok = 1'b1;
      ok &= field_ok("stall_res", want.stall_res, got.stall_res);
      ok &= field_ok("redirect", want.redirect, got.redirect);
      ok &= field_ok("target_pc", want.target_pc, got.target_pc);
      ok &= field_ok("link_write", want.link_write, got.link_write);
      ok &= field_ok("link_value", want.link_value, got.link_value);
      ok &= field_ok("halt", want.halt, got.halt);
      ok &= field_ok("issue_valid", want.issue_valid, got.issue_valid);
      ok &= field_ok("opcode_out", want.opcode_out, got.opcode_out);
      ok &= field_ok("dest_or_store", want.dest_or_store, got.dest_or_store);
      ok &= field_ok("src_a_value", want.src_a_value, got.src_a_value);
      ok &= field_ok("src_b_value", want.src_b_value, got.src_b_value);
      ok &= field_ok("writes_register", want.writes_register, got.writes_register);
      if (!ok) mismatches++;
    endfunction
  endclass

  logic clk;
  logic rst;

  pdhb_in_if  instr_in ();
  pdhb_out_if dec_out ();

  decode_result_tracker tracker;

  pipeline_decode_hazard_branch_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .instr_in (instr_in),
    .dec_out  (dec_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Small fields come in as int and are cut to their widths here
  function automatic dec_in_t make_item(logic [OP_BITS-1:0] op, int rd, int rs, int rt,
                                        logic [IMM_BITS-1:0] imm, logic [WORD_BITS-1:0] a,
                                        logic [WORD_BITS-1:0] b, logic [WORD_BITS-1:0] d,
                                        int pc, int dests, int writes);
    dec_in_t item;
    item.slot_valid   = 1'b1;
    item.instruction  = {op, REG_BITS'(rd), REG_BITS'(rs), REG_BITS'(rt), imm};
    item.fetch_pc     = FPC_BITS'(pc);
    item.src_a_raw    = a;
    item.src_b_raw    = b;
    item.dest_raw     = d;
    item.later_dests  = DESTS_BITS'(dests);
    item.later_writes = STAGES'(writes);
    return item;
  endfunction

  function automatic dec_in_t random_item();
    dec_in_t item;
    item.slot_valid  = $urandom_range(0, 9) != 0;
    item.instruction = $urandom;
    if ($urandom_range(0, 3) != 0)
      item.instruction[31:24] = OP_BITS'($urandom_range(0, OP_HALT));
    item.fetch_pc     = FPC_BITS'($urandom);
    item.src_a_raw    = $urandom;
    item.src_b_raw    = $urandom;
    item.dest_raw     = $urandom;
    item.later_dests  = DESTS_BITS'($urandom);
    item.later_writes = STAGES'($urandom);
    // Steer compares toward equal and sign-boundary operands
    case ($urandom_range(0, 7))
      0: item.src_b_raw = item.src_a_raw;
      1: item.src_a_raw = 32'h8000_0000;
      2: item.src_b_raw = 32'h7FFF_FFFF;
      3: item.src_b_raw = item.src_a_raw + 32'd1;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) item.later_writes = '0;
    return item;
  endfunction

  // Present one instruction after a gap and hold it until taken
  task automatic send_item(dec_in_t item, int gap);
    if (gap > 0) begin
      instr_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_in.valid <= 1'b1;
    instr_in.data  <= item;
    do @(posedge clk); while (!instr_in.ready);
    tracker.note_input(item);
  endtask

  task automatic wait_drained();
    instr_in.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    dec_in_t item;
    // Bubble and all-ones word: undefined opcode, no hazard check
    item = make_item(OP_MAX, 4'hF, 4'hF, 4'hF, 12'hFFF, '1, '1, '1, 10'h3FF, 12'hFFF, 3'h7);
    item.slot_valid = 1'b0;
    send_item(item, idle_gap());
    item.slot_valid = 1'b1;
    send_item(item, idle_gap());
    send_item(make_item(OP_ALU0, 0, 0, 0, 12'h000, 0, 0, 0, 0, 0, 0), idle_gap());
    // Immediate register, both signs
    send_item(make_item(OP_ALU0, 2, 1, 1, 12'h800, 5, 6, 7, 1, 0, 0), idle_gap());
    send_item(make_item(OP_ALU_LAST, 3, 1, 0, 12'h7FF, 5, 6, 7, 2, 0, 0), idle_gap());
    // Branches, target from rd
    send_item(make_item(OP_BEQ, 1, 4, 5, 12'hFFF, 32'h1234, 32'h1234, 0, 3, 0, 0),
              idle_gap());
    send_item(make_item(OP_BNE, 6, 4, 5, 12'h0, 32'h1234, 32'h1234, 32'h55, 4, 0, 0),
              idle_gap());
    send_item(make_item(OP_BNE, 6, 4, 5, 12'h0, 32'h1, 32'h2, 32'h12345, 5, 0, 0),
              idle_gap());
    send_item(make_item(OP_BLT, 6, 4, 5, 12'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h2A, 6,
                        0, 0), idle_gap());
    send_item(make_item(OP_BGT, 6, 4, 5, 12'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h2B, 7,
                        0, 0), idle_gap());
    send_item(make_item(OP_BGT, 6, 4, 5, 12'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h2C, 8,
                        0, 0), idle_gap());
    send_item(make_item(OP_BLE, 6, 4, 5, 12'h0, 32'h77, 32'h77, 32'h2D, 9, 0, 0), idle_gap());
    send_item(make_item(OP_BLE, 6, 4, 5, 12'h0, 32'h1, '1, 32'h2E, 10, 0, 0), idle_gap());
    send_item(make_item(OP_BGE, 6, 4, 5, 12'h0, '1, 32'h0, 32'h2F, 11, 0, 0), idle_gap());
    send_item(make_item(OP_BGE, 6, 4, 5, 12'h0, 32'h9, 32'h9, 32'h30, 12, 0, 0), idle_gap());
    // jal at the top pc, source indices match later dests but are not checked
    send_item(make_item(OP_JAL, 5, 7, 7, 12'h0, 1, 2, '1, 10'h3FF, 12'h777, 3'h7),
              idle_gap());
    // Hazards: load on rs, store on rd, rt on the middle stage
    send_item(make_item(OP_LOAD, 2, 6, 0, 12'h0, 1, 2, 3, 13, 12'h006, 3'h1), idle_gap());
    send_item(make_item(OP_STORE, 9, 0, 1, 12'h0, 1, 2, 32'hCAFE, 14, 12'h900, 3'h4),
              idle_gap());
    send_item(make_item(OP_STORE, 9, 0, 1, 12'h0, 1, 2, 32'hCAFE, 15, 12'h900, 3'h3),
              idle_gap());
    send_item(make_item(OP_ALU_MID, 7, 2, 3, 12'h0, 1, 2, 3, 16, 12'h777, 3'h7), idle_gap());
    send_item(make_item(OP_ALU_MID, 7, 2, 4'hB, 12'h0, 1, 2, 3, 17, 12'h0B0, 3'h2),
              idle_gap());
    send_item(make_item(OP_ALU_MID, 7, 1, 1, 12'h321, 1, 2, 3, 18, 12'h111, 3'h7),
              idle_gap());
    // Halt and undefined opcodes skip the hazard check
    send_item(make_item(OP_HALT, 4, 4, 4, 12'h0, 1, 2, 3, 19, 12'h444, 3'h7), idle_gap());
    send_item(make_item(OP_UNDEF_LO, 8, 8, 8, 12'h0, 1, 2, 3, 20, 12'h888, 3'h7), idle_gap());
    send_item(make_item(OP_UNDEF_HI, 3, 2, 2, 12'h0, 1, 2, 3, 21, 12'h222, 3'h7), idle_gap());
    send_item(make_item(OP_UNDEF_NEXT, 3, 5, 6, 12'h0, 1, 2, 3, 22, 12'h650, 3'h7),
              idle_gap());
  endtask

  // Result side: random ready with stalls and stall-free stretches
  initial begin
    int run, stall;
    dec_out.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      dec_out.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = idle_gap();
      if (stall > 0) begin
        dec_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (!rst && dec_out.valid && dec_out.ready)
      tracker.check_result(dec_out.data);
  end

  // Watchdog on cycles with no item moving on either channel
  initial begin
    int idle;
    idle = 0;
    while (rst !== 1'b0) @(posedge clk);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((instr_in.valid && instr_in.ready) || (dec_out.valid && dec_out.ready))
        idle = 0;
      else
        idle++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    int burst_left, gap;
    tracker        = new();
    rst            = 1'b1;
    instr_in.valid = 1'b0;
    instr_in.data  = '0;
    burst_left     = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    wait_drained();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (burst_left == 0 && $urandom_range(0, 99) == 0)
        burst_left = $urandom_range(20, 60);
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = idle_gap();
      end
      send_item(random_item(), gap);
      if ($urandom_range(0, 199) == 0) wait_drained();
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[pipeline_decode_hazard_branch_unit.f]
sv/pdhb_pkg.sv
sv/pdhb_in_if.sv
sv/pdhb_out_if.sv
sv/pdhb_decode.sv
sv/pipeline_decode_hazard_branch_unit.sv
tb/pipeline_decode_hazard_branch_unit_tb.sv
